>>> hw/rtl/mkfc_pkg.sv
package mkfc_pkg;

  localparam int HASH_W   = 30;
  localparam int COUNT_W  = 17;
  localparam int LETTER_W = 5;
  localparam int EPOCH_W  = 8;
  localparam int ALPHABET = 26;

  localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

  localparam logic [HASH_W-1:0] P    = 30'd1000000007;
  localparam logic [HASH_W-1:0] INV  = 30'd129032259;
  localparam logic [HASH_W-1:0] BASE = 30'd31;
  // Barrett factor, floor(2^60 / P)
  localparam logic [31:0] MU = 32'((64'd1 << 60) / 64'd1000000007);

  localparam logic [COUNT_W-1:0] COUNT_CEIL = 17'h1FFFF;

  localparam logic REG_WINDOW_SIZE  = 1'b0;
  localparam logic REG_MAX_DISTINCT = 1'b1;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] res;
  } mm_rsp_t;

endpackage

>>> hw/rtl/mkfc_ram.sv
module mkfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mkfc_modmul.sv
// a * b mod P by Barrett reduction, at most one multiply per stage; registered stages pa, t, qp, r and res
module mkfc_modmul (
  input  logic              clk,
  input  logic              rst,
  input  mkfc_pkg::mm_req_t req,
  output mkfc_pkg::mm_rsp_t rsp
);

  logic [59:0] pa;
  logic [62:0] t;
  logic [31:0] qp;
  logic [31:0] r;
  logic [3:0]  stage_v;
  logic [31:0] p2;
  logic [31:0] p1;

  assign p1 = 32'(mkfc_pkg::P);
  assign p2 = 32'(mkfc_pkg::P) << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v  <= '0;
      rsp.done <= 1'b0;
    end else begin
      stage_v  <= {stage_v[2:0], req.start};
      rsp.done <= stage_v[3];
    end
    if (req.start) begin
      pa <= 60'(req.a) * 60'(req.b);
    end
    t  <= 63'(pa[59:29]) * 63'(mkfc_pkg::MU);
    qp <= 32'(64'(t[61:31]) * 64'(mkfc_pkg::P));
    r  <= pa[31:0] - qp;
    // estimate is short by at most two
    if (r >= p2) begin
      rsp.res <= 30'(r - p2);
    end else if (r >= p1) begin
      rsp.res <= 30'(r - p1);
    end else begin
      rsp.res <= 30'(r);
    end
  end

endmodule

>>> hw/rtl/max_kgram_frequency_counter.sv
// Each letter steps through the states from DEC to FIN; a counted window probes the count
// table, and each further probe is one RAM read and compare (states RD and CMP).
// A letter still filling the window, or a window not counted, skips the probe.
// The result is loaded in FIN after the last letter, once the output is free. One letter in flight.
// Reset (synchronous): registers to window_size 1, max_distinct 26; a clearing pass
// writes every table entry, and runs again after every 255th string.
module max_kgram_frequency_counter #(
  parameter int WINDOW_MAX  = 32,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  letter,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] max_count,
  output logic        table_overflow
);

  localparam int KW  = $clog2(WINDOW_MAX + 1);
  localparam int WIX = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int DW  = $clog2(TABLE_DEPTH);
  localparam int SHR = mkfc_pkg::HASH_W + DW;
  localparam logic [31:0] RECIP = 32'((64'd1 << SHR) / 64'(TABLE_DEPTH));
  localparam int RW = mkfc_pkg::EPOCH_W + mkfc_pkg::HASH_W + mkfc_pkg::COUNT_W;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DEC   = 4'd2;
  localparam logic [3:0] ST_M1    = 4'd3;
  localparam logic [3:0] ST_W1    = 4'd4;
  localparam logic [3:0] ST_M2    = 4'd5;
  localparam logic [3:0] ST_W2    = 4'd6;
  localparam logic [3:0] ST_M3    = 4'd7;
  localparam logic [3:0] ST_W3    = 4'd8;
  localparam logic [3:0] ST_CHK   = 4'd9;
  localparam logic [3:0] ST_S1    = 4'd10;
  localparam logic [3:0] ST_S2    = 4'd11;
  localparam logic [3:0] ST_S3    = 4'd12;
  localparam logic [3:0] ST_RD    = 4'd13;
  localparam logic [3:0] ST_CMP   = 4'd14;
  localparam logic [3:0] ST_FIN   = 4'd15;

  logic [3:0]    state;
  logic [5:0]    window_size;
  logic [4:0]    max_distinct;
  logic [4:0]    wl [WINDOW_MAX];
  logic [KW-1:0] lc [mkfc_pkg::ALPHABET];
  logic [4:0]    distinct;
  logic [KW-1:0] fill;
  logic [29:0]   h;
  logic [29:0]   tp;
  logic [mkfc_pkg::EPOCH_W-1:0] epoch;
  logic [16:0]   best;
  logic          ov;
  logic [4:0]    cur_c;
  logic [4:0]    cur_o;
  logic          cur_last;
  logic          cur_full;
  logic [61:0]   sp;
  logic [29:0]   sq;
  logic [DW-1:0] slot;
  logic [DW-1:0] tries;
  logic [DW-1:0] clr_addr;

  logic [KW-1:0] k;
  logic [KW-1:0] km1;
  logic [4:0]    lc_addr;
  logic [KW-1:0] lc_rd;
  logic [29:0]   o1;
  logic [29:0]   hx;
  logic [30:0]   hsum;
  logic [29:0]   hadd;
  logic [29:0]   q_est;
  logic [29:0]   rr;
  logic          out_free;
  logic          clr_win;
  logic [4:0]    c_in;

  logic          ram_we;
  logic [DW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic [mkfc_pkg::EPOCH_W-1:0] rd_tag;
  logic [29:0]   rd_key;
  logic [16:0]   rd_cnt;
  logic          rd_empty;
  logic          rd_hit;
  logic [16:0]   new_cnt;

  mkfc_pkg::mm_req_t mm_req;
  mkfc_pkg::mm_rsp_t mm_rsp;

  mkfc_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  mkfc_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (window_size == 6'd0) begin
      k = KW'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = KW'(window_size);
    end
  end

  assign km1      = k - KW'(1);
  assign in_stall = (state != ST_IDLE);
  assign c_in     = (letter > mkfc_pkg::LAST_LETTER) ? mkfc_pkg::LAST_LETTER : letter;
  assign lc_addr  = (state == ST_DEC) ? cur_o : cur_c;
  assign lc_rd    = lc[lc_addr];

  assign o1   = 30'(cur_o) + 30'd1;
  assign hx   = (h >= o1) ? (h - o1) : (h + (mkfc_pkg::P - o1));
  assign hsum = {1'b0, h} + {1'b0, mm_rsp.res};
  assign hadd = (hsum >= 31'(mkfc_pkg::P)) ? 30'(hsum - 31'(mkfc_pkg::P)) : 30'(hsum);

  assign q_est = 30'(sp >> SHR);
  assign rr    = h - sq;

  assign rd_tag   = ram_rdata[RW-1 -: mkfc_pkg::EPOCH_W];
  assign rd_key   = ram_rdata[mkfc_pkg::COUNT_W +: mkfc_pkg::HASH_W];
  assign rd_cnt   = ram_rdata[mkfc_pkg::COUNT_W-1:0];
  assign rd_empty = (rd_tag != epoch);
  assign rd_hit   = !rd_empty && (rd_key == h);
  assign new_cnt  = rd_empty ? 17'd1 :
                    (rd_cnt == mkfc_pkg::COUNT_CEIL) ? rd_cnt : rd_cnt + 17'd1;

  assign ram_we    = (state == ST_CLEAR) || ((state == ST_CMP) && (rd_empty || rd_hit));
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : slot;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : {epoch, h, new_cnt};

  assign out_free = !(out_valid && out_stall);
  assign clr_win  = (cfg_write && (cfg_index == mkfc_pkg::REG_WINDOW_SIZE)) ||
                    ((state == ST_FIN) && cur_last && out_free);

  always_comb begin
    mm_req.start = (state == ST_M1) || (state == ST_M2) || (state == ST_M3);
    if (state == ST_M1) begin
      mm_req.a = h;
      mm_req.b = mkfc_pkg::INV;
    end else if (state == ST_M2) begin
      mm_req.a = 30'(cur_c) + 30'd1;
      mm_req.b = tp;
    end else begin
      mm_req.a = tp;
      mm_req.b = mkfc_pkg::BASE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      window_size  <= 6'd1;
      max_distinct <= 5'd26;
      for (int i = 0; i < mkfc_pkg::ALPHABET; i++) begin
        lc[i] <= '0;
      end
      distinct  <= '0;
      fill      <= '0;
      h         <= '0;
      tp        <= 30'd1;
      epoch     <= mkfc_pkg::EPOCH_W'(1);
      best      <= '0;
      ov        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a last letter in FIN reloads the result itself
      if (out_valid && !out_stall && !((state == ST_FIN) && cur_last)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + DW'(1);
          if (clr_addr == DW'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cur_c    <= c_in;
            cur_last <= last;
            cur_o    <= wl[km1[WIX-1:0]];
            cur_full <= (fill >= k);
            state    <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (cur_full) begin
            if (lc_rd != '0) begin
              lc[cur_o] <= lc_rd - KW'(1);
              if ((lc_rd == KW'(1)) && (distinct != '0)) begin
                distinct <= distinct - 5'd1;
              end
            end
            h     <= hx;
            state <= ST_M1;
          end else begin
            state <= ST_M2;
          end
        end
        ST_M1: state <= ST_W1;
        ST_W1: begin
          if (mm_rsp.done) begin
            h     <= mm_rsp.res;
            state <= ST_M2;
          end
        end
        ST_M2: state <= ST_W2;
        ST_W2: begin
          if (mm_rsp.done) begin
            h         <= hadd;
            lc[cur_c] <= lc_rd + KW'(1);
            if (lc_rd == '0) begin
              distinct <= distinct + 5'd1;
            end
            for (int i = WINDOW_MAX - 1; i > 0; i--) begin
              wl[i] <= wl[i-1];
            end
            wl[0] <= cur_c;
            if (!cur_full) begin
              fill <= fill + KW'(1);
              state <= ((fill + KW'(1)) < k) ? ST_M3 : ST_CHK;
            end else begin
              state <= ST_CHK;
            end
          end
        end
        ST_M3: state <= ST_W3;
        ST_W3: begin
          if (mm_rsp.done) begin
            tp    <= mm_rsp.res;
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          state <= ((fill == k) && (distinct <= max_distinct)) ? ST_S1 : ST_FIN;
        end
        ST_S1: begin
          sp    <= 62'(h) * 62'(RECIP);
          state <= ST_S2;
        end
        ST_S2: begin
          sq    <= 30'(q_est * 30'(TABLE_DEPTH));
          state <= ST_S3;
        end
        ST_S3: begin
          slot  <= (rr >= 30'(TABLE_DEPTH)) ? DW'(rr - 30'(TABLE_DEPTH)) : DW'(rr);
          tries <= '0;
          state <= ST_RD;
        end
        ST_RD: state <= ST_CMP;
        ST_CMP: begin
          if (rd_empty || rd_hit) begin
            if (new_cnt > best) begin
              best <= new_cnt;
            end
            state <= ST_FIN;
          end else if (tries == DW'(TABLE_DEPTH - 1)) begin
            ov    <= 1'b1;
            state <= ST_FIN;
          end else begin
            tries <= tries + DW'(1);
            slot  <= (slot == DW'(TABLE_DEPTH - 1)) ? '0 : slot + DW'(1);
            state <= ST_RD;
          end
        end
        ST_FIN: begin
          if (!cur_last) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            max_count      <= best;
            table_overflow <= ov;
            out_valid      <= 1'b1;
            best           <= '0;
            ov             <= 1'b0;
            // epoch wrap: old tags could alias, so sweep the table
            if (epoch == '1) begin
              epoch    <= mkfc_pkg::EPOCH_W'(1);
              clr_addr <= '0;
              state    <= ST_CLEAR;
            end else begin
              epoch <= epoch + mkfc_pkg::EPOCH_W'(1);
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg_write) begin
        case (cfg_index)
          mkfc_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data;
          mkfc_pkg::REG_MAX_DISTINCT: max_distinct <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (clr_win) begin
        for (int i = 0; i < mkfc_pkg::ALPHABET; i++) begin
          lc[i] <= '0;
        end
        distinct <= '0;
        fill     <= '0;
        h        <= '0;
        tp       <= 30'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_modmul_range: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (mm_rsp.res < mkfc_pkg::P))
    else $error("modular product not reduced");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (32'(slot) < 32'(TABLE_DEPTH)))
    else $error("probe slot beyond table");

  a_distinct_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (32'(distinct) <= 32'(fill)))
    else $error("more distinct letters than letters in window");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && cur_last && out_free) |=> out_valid)
    else $error("last letter gave no result");
`endif

endmodule
